// ----- rtl/sdu_pkg.sv -----
// ----------------------------------------------------------------------------
// sdu_pkg
// Shared types and constants for the sorted distinct union block: action
// codes, sequencer states and the control bundle of the compare unit.
// ----------------------------------------------------------------------------
package sdu_pkg;

	// width of one element value
	localparam int VAL_W = 32;

	// default capacity of each list
	localparam int MAX_LEN_DEF = 32;

	// action codes of an input transfer
	localparam logic [1:0] ACT_FIRST  = 2'd0;
	localparam logic [1:0] ACT_SECOND = 2'd1;
	localparam logic [1:0] ACT_EMIT   = 2'd2;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WAIT,
		ST_DONE,
		ST_EMPTY
	} state_t;

	// control bundle from the sequencer to the compare unit
	typedef struct packed {
		logic clear;     // forget the running minimum
		logic load;      // read data is valid this cycle
		logic use_prev;  // only take values above the last emitted one
	} scan_ctl_t;

endpackage

// ----- rtl/sdu_ram.sv -----
// ----------------------------------------------------------------------------
// sdu_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module sdu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- rtl/sdu_scan_unit.sv -----
// ----------------------------------------------------------------------------
// sdu_scan_unit
// Shared compare unit: keeps the smallest value seen in one pass over the
// store that lies strictly above the last emitted value.
// ----------------------------------------------------------------------------
module sdu_scan_unit
	import sdu_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  scan_ctl_t               ctl,
	input  logic signed [VAL_W-1:0] data,
	input  logic signed [VAL_W-1:0] prev,
	output logic                    found,
	output logic signed [VAL_W-1:0] best
);

	logic                    found_q;
	logic signed [VAL_W-1:0] best_q;
	logic                    above_prev;
	logic                    below_best;
	logic                    take;

	// signed compares against the floor and the running minimum
	assign above_prev = !ctl.use_prev || (data > prev);
	assign below_best = !found_q || (data < best_q);
	assign take       = ctl.load && above_prev && below_best;

	// candidate flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.clear) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	// running minimum
	always_ff @(posedge clk) begin
		if (take) begin
			best_q <= data;
		end
	end

	assign found = found_q;
	assign best  = best_q;

endmodule

// ----- rtl/sorted_distinct_union.sv -----
// ----------------------------------------------------------------------------
// sorted_distinct_union
// Collects signed values into two lists and, on request, emits their union
// in ascending order with every value given once.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (item_valid / item_stall): action 0 appends value to the
//   first list, action 1 to the second, action 2 starts the emit, action 3
//   is ignored. An append gives no result; an append to
//   a full list is dropped and sets the sticky overflow flag.
//   Output channel (res_valid / res_stall): one transfer per distinct value,
//   ascending, last set on the final one, overflow the same on all of them.
//   With both lists empty a single transfer carries value 0, last and
//   empty_res.
//   Emit: the block makes one pass over the n stored values for each
//   distinct value plus a final pass, each pass reading the n values, then
//   taking the last read, then deciding, through the single compare unit
//   and the one read port of the store; item_stall stays high for the whole
//   run, after which counts and the flag are cleared.
//   A stalled receiver holds the output register and the sequencer waits
//   for it before handing over the next value.
//   Reset clears the counts, the flag and the sequencer; store contents
//   need no clearing since only counted entries are read.
// ----------------------------------------------------------------------------
module sorted_distinct_union
	import sdu_pkg::*;
#(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	output logic                    item_stall,
	input  logic [1:0]              action,
	input  logic signed [VAL_W-1:0] value,
	output logic                    res_valid,
	input  logic                    res_stall,
	output logic signed [VAL_W-1:0] value_res,
	output logic                    last,
	output logic                    empty_res,
	output logic                    overflow
);

	localparam int DEPTH = 2 * MAX_LEN;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(MAX_LEN + 1);
	localparam int NW    = $clog2(DEPTH + 1);

	state_t                  state_q, state_d;
	logic [CW-1:0]           cnt_a_q, cnt_a_d;
	logic [CW-1:0]           cnt_b_q, cnt_b_d;
	logic                    dropped_q, dropped_d;
	logic [NW-1:0]           n_q, n_d;
	logic [NW-1:0]           idx_q, idx_d;
	logic [NW-1:0]           n_total;
	logic                    have_prev_q, have_prev_d;
	logic signed [VAL_W-1:0] prev_q, prev_d;
	logic                    pend_valid_q, pend_valid_d;
	logic signed [VAL_W-1:0] pend_q, pend_d;
	logic                    rd_s1;

	logic                    wr_en;
	logic [AW-1:0]           wr_addr;
	logic                    rd_en;
	logic [AW-1:0]           rd_addr;
	logic signed [VAL_W-1:0] rd_data;

	scan_ctl_t               ctl;
	logic                    found;
	logic signed [VAL_W-1:0] best;

	logic                    out_free;
	logic                    push;
	logic signed [VAL_W-1:0] push_val;
	logic                    push_last;
	logic                    push_empty;

	logic                    res_valid_q;
	logic signed [VAL_W-1:0] value_q;
	logic                    last_q;
	logic                    empty_q;
	logic                    ovf_q;

	// element store
	sdu_ram #(
		.WIDTH (VAL_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (value),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// shared compare unit
	sdu_scan_unit u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.data   (rd_data),
		.prev   (prev_q),
		.found  (found),
		.best   (best)
	);

	// store addressing: first list low half, second list high half
	assign n_total = NW'(cnt_a_q) + NW'(cnt_b_q);
	assign wr_addr = (action == ACT_FIRST) ? AW'(cnt_a_q)
	                                       : AW'(NW'(cnt_b_q) + NW'(MAX_LEN));
	assign rd_addr = (idx_q < NW'(cnt_a_q)) ? AW'(idx_q)
	               : AW'(idx_q - NW'(cnt_a_q) + NW'(MAX_LEN));

	assign item_stall   = (state_q != ST_IDLE);
	assign out_free     = !res_valid_q || !res_stall;

	// sequencer: next state and datapath controls
	always_comb begin
		state_d      = state_q;
		cnt_a_d      = cnt_a_q;
		cnt_b_d      = cnt_b_q;
		dropped_d    = dropped_q;
		n_d          = n_q;
		idx_d        = idx_q;
		have_prev_d  = have_prev_q;
		prev_d       = prev_q;
		pend_valid_d = pend_valid_q;
		pend_d       = pend_q;
		ctl.clear    = 1'b0;
		ctl.load     = rd_s1;
		ctl.use_prev = have_prev_q;
		wr_en        = 1'b0;
		rd_en        = 1'b0;
		push         = 1'b0;
		push_val     = pend_q;
		push_last    = 1'b0;
		push_empty   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					unique case (action)
						ACT_FIRST: begin
							if (cnt_a_q < CW'(MAX_LEN)) begin
								wr_en   = 1'b1;
								cnt_a_d = cnt_a_q + CW'(1);
							end else begin
								dropped_d = 1'b1;
							end
						end
						ACT_SECOND: begin
							if (cnt_b_q < CW'(MAX_LEN)) begin
								wr_en   = 1'b1;
								cnt_b_d = cnt_b_q + CW'(1);
							end else begin
								dropped_d = 1'b1;
							end
						end
						ACT_EMIT: begin
							n_d          = n_total;
							idx_d        = '0;
							have_prev_d  = 1'b0;
							pend_valid_d = 1'b0;
							ctl.clear    = 1'b1;
							state_d      = (n_total == '0) ? ST_EMPTY : ST_SCAN;
						end
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				rd_en = 1'b1;
				idx_d = idx_q + NW'(1);
				if (idx_q == n_q - NW'(1)) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!pend_valid_q || out_free) begin
					// hand over the held value once we know whether more follow
					push      = pend_valid_q;
					push_last = !found;
					if (found) begin
						pend_d       = best;
						pend_valid_d = 1'b1;
						prev_d       = best;
						have_prev_d  = 1'b1;
						ctl.clear    = 1'b1;
						idx_d        = '0;
						state_d      = ST_SCAN;
					end else begin
						cnt_a_d   = '0;
						cnt_b_d   = '0;
						dropped_d = 1'b0;
						state_d   = ST_IDLE;
					end
				end
			end
			ST_EMPTY: begin
				if (out_free) begin
					push       = 1'b1;
					push_val   = '0;
					push_last  = 1'b1;
					push_empty = 1'b1;
					cnt_a_d    = '0;
					cnt_b_d    = '0;
					dropped_d  = 1'b0;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer and count registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_a_q      <= '0;
			cnt_b_q      <= '0;
			dropped_q    <= 1'b0;
			n_q          <= '0;
			idx_q        <= '0;
			have_prev_q  <= 1'b0;
			pend_valid_q <= 1'b0;
			rd_s1        <= 1'b0;
		end else begin
			state_q      <= state_d;
			cnt_a_q      <= cnt_a_d;
			cnt_b_q      <= cnt_b_d;
			dropped_q    <= dropped_d;
			n_q          <= n_d;
			idx_q        <= idx_d;
			have_prev_q  <= have_prev_d;
			pend_valid_q <= pend_valid_d;
			rd_s1        <= rd_en;
		end
	end

	// held value and floor of the next pass
	always_ff @(posedge clk) begin
		prev_q <= prev_d;
		pend_q <= pend_d;
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (push) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (push) begin
			value_q <= push_val;
			last_q  <= push_last;
			empty_q <= push_empty;
			ovf_q   <= dropped_q;
		end
	end

	assign res_valid = res_valid_q;
	assign value_res = value_q;
	assign last      = last_q;
	assign empty_res = empty_q;
	assign overflow  = ovf_q;

	// counts never pass the list capacity
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_a_q <= CW'(MAX_LEN)) && (cnt_b_q <= CW'(MAX_LEN)))
		else $error("list count above capacity");

	// a run ends with counts and flag cleared
	a_run_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) && (state_d == ST_IDLE) |=>
		(cnt_a_q == '0) && (cnt_b_q == '0) && !dropped_q)
		else $error("state not cleared after emit");

	// scan index stays inside the gathered lists
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (idx_q < n_q))
		else $error("scan index out of range");

	// empty result is a single final zero
	a_empty_form: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && empty_res |-> last && (value_res == '0))
		else $error("malformed empty result");

	// each new floor lies strictly above the previous one
	a_ascending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) && have_prev_q && found |-> (best > prev_q))
		else $error("values not strictly ascending");

endmodule
